/* design/reloading_irq_cycle_counter_assert.svh */
// Assertion macros used by the checker of the reloading IRQ cycle counter.
`ifndef RELOADING_IRQ_CYCLE_COUNTER_ASSERT_SVH
`define RELOADING_IRQ_CYCLE_COUNTER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define RIRQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define RIRQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/rirq_pkg.sv */
// Package with the item type, register codes and control bit positions of the counter.
`timescale 1ns / 1ps
`default_nettype none

package rirq_pkg;

    localparam int CountWidth  = 16;
    localparam int NibbleWidth = 4;
    localparam int SelWidth    = 3;
    localparam int DataWidth   = 8;
    localparam int CtrlWidth   = 3;

    localparam logic [SelWidth-1:0] REG_NIB0 = 3'd0;
    localparam logic [SelWidth-1:0] REG_NIB1 = 3'd1;
    localparam logic [SelWidth-1:0] REG_NIB2 = 3'd2;
    localparam logic [SelWidth-1:0] REG_NIB3 = 3'd3;
    localparam logic [SelWidth-1:0] REG_CTRL = 3'd4;
    localparam logic [SelWidth-1:0] REG_ACK  = 3'd5;

    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    localparam int CTRL_ACK_ENABLE = 0;
    localparam int CTRL_ENABLE     = 1;
    localparam int CTRL_MODE8      = 2;

    typedef struct packed {
        logic                 func;
        logic [SelWidth-1:0]  reg_select;
        logic [DataWidth-1:0] write_data;
    } item_t;

endpackage

`default_nettype wire

/* design/rirq_in_stage.sv */
// Input register of the counter: holds one accepted item until the state update takes it.
`timescale 1ns / 1ps
`default_nettype none

module rirq_in_stage (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire rirq_pkg::item_t in_item,
    output logic                item_valid,
    input  wire logic           item_take,
    output rirq_pkg::item_t     item
);

    logic            valid_reg;
    logic            valid_next;
    rirq_pkg::item_t item_reg;

    assign in_ready   = !valid_reg || item_take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !item_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

/* design/rirq_core.sv */
// Counter state and its update for one item: reload nibbles, control, acknowledge and tick.
`timescale 1ns / 1ps
`default_nettype none

module rirq_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_fire,
    input  wire rirq_pkg::item_t item,
    output logic                 irq_next
);

    logic [rirq_pkg::CountWidth-1:0] reload_reg;
    logic [rirq_pkg::CountWidth-1:0] reload_next;
    logic [rirq_pkg::CountWidth-1:0] count_reg;
    logic [rirq_pkg::CountWidth-1:0] count_next;
    logic [rirq_pkg::CtrlWidth-1:0]  ctrl_reg;
    logic [rirq_pkg::CtrlWidth-1:0]  ctrl_next;
    logic                            irq_reg;
    logic                            irq_calc;
    logic [rirq_pkg::NibbleWidth-1:0] nib;
    logic                            at_top;

    assign nib = item.write_data[rirq_pkg::NibbleWidth-1:0];

    // The counter matches when every bit under the selected mask is one.
    assign at_top = ctrl_reg[rirq_pkg::CTRL_MODE8] ? (&count_reg[7:0]) : (&count_reg);

    always_comb
    begin
        reload_next = reload_reg;
        count_next  = count_reg;
        ctrl_next   = ctrl_reg;
        irq_calc    = irq_reg;
        if (item.func == rirq_pkg::FUNC_WRITE)
        begin
            unique case (item.reg_select)
                rirq_pkg::REG_NIB0: reload_next[3:0]   = nib;
                rirq_pkg::REG_NIB1: reload_next[7:4]   = nib;
                rirq_pkg::REG_NIB2: reload_next[11:8]  = nib;
                rirq_pkg::REG_NIB3: reload_next[15:12] = nib;
                rirq_pkg::REG_CTRL:
                begin
                    ctrl_next = item.write_data[rirq_pkg::CtrlWidth-1:0];
                    if (ctrl_next[rirq_pkg::CTRL_ENABLE])
                    begin
                        count_next = reload_reg;
                    end
                    irq_calc = 1'b0;
                end
                rirq_pkg::REG_ACK:
                begin
                    ctrl_next[rirq_pkg::CTRL_ENABLE] = ctrl_reg[rirq_pkg::CTRL_ACK_ENABLE];
                    irq_calc = 1'b0;
                end
                default:
                begin
                    reload_next = reload_reg;
                end
            endcase
        end
        else if (ctrl_reg[rirq_pkg::CTRL_ENABLE])
        begin
            if (at_top)
            begin
                count_next = reload_reg;
                irq_calc   = 1'b1;
            end
            else
            begin
                count_next = count_reg + 16'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reload_reg <= '0;
            count_reg  <= '0;
            ctrl_reg   <= '0;
            irq_reg    <= 1'b0;
        end
        else if (item_fire)
        begin
            reload_reg <= reload_next;
            count_reg  <= count_next;
            ctrl_reg   <= ctrl_next;
            irq_reg    <= irq_calc;
        end
    end

    assign irq_next = irq_calc;

endmodule

`default_nettype wire

/* design/reloading_irq_cycle_counter.sv */
// Top level of the reloading IRQ cycle counter: input register, state update, result register.
// An accepted item passes the input register, then the result register. Throughput: one item
// per cycle unless the output stalls; the state update is a single 16-bit increment and compare.
// The result register lets a new item enter while a finished result still waits.
// Reset (rst_n low, asynchronous): counter, reload value, control bits and IRQ clear,
// and both the input and the result register become empty.
`timescale 1ns / 1ps
`default_nettype none

module reloading_irq_cycle_counter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // [2:0] reg_select, [10:3] write_data, rest zero
    input  wire logic [0:0]  s_axis_tuser,  // [0] func
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata   // [0] irq_active, rest zero
);

    rirq_pkg::item_t in_item;
    rirq_pkg::item_t item;
    logic            item_valid;
    logic            item_take;
    logic            irq_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            irq_out_reg;

    assign in_item.func       = s_axis_tuser[0];
    assign in_item.reg_select = s_axis_tdata[2:0];
    assign in_item.write_data = s_axis_tdata[10:3];

    assign item_take = item_valid && (!out_valid_reg || m_axis_tready);

    rirq_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item)
    );

    rirq_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_fire (item_take),
        .item      (item),
        .irq_next  (irq_next)
    );

    assign out_valid_next = item_take || (out_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            irq_out_reg <= irq_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, irq_out_reg};

endmodule

`default_nettype wire

/* design/rirq_checker.sv */
// Port-level checker of the reloading IRQ cycle counter and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "reloading_irq_cycle_counter_assert.svh"

module rirq_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [7:0]  m_axis_tdata
);

    logic s_acc;

    assign s_acc = s_axis_tvalid && s_axis_tready;

    // A held result keeps its value until it is taken.
    `RIRQ_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    // The input side stalls only when a result is waiting and not being taken.
    `RIRQ_ASSERT_SAME(a_in_stall_cause, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled without output backpressure")

    // With the output empty and no item accepted that could still sit in the input register, no result can appear.
    `RIRQ_ASSERT_SAME(a_no_phantom, !$past(m_axis_tvalid) && !$past(s_acc) && !$past(s_acc, 2), !m_axis_tvalid, "result without an accepted item")

endmodule

bind reloading_irq_cycle_counter rirq_checker u_rirq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

/* dv/irq_counter_checker.sv */
`timescale 1ns / 1ps
// Checker that mirrors the IRQ counter state and compares every result item.
module irq_counter_checker
    import rirq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [2:0] reg_select, [10:3] write_data, rest zero
    input  logic [0:0]  s_axis_tuser,  // [0] func
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,  // [0] irq_active, rest zero
    output int          mismatches,
    output int          results_pending
);

    logic [CountWidth-1:0] reload_val;
    logic [CountWidth-1:0] count_val;
    logic [CtrlWidth-1:0]  ctrl_bits;
    logic                  irq_flag;
    logic                  irq_expect_q[$];
    logic                  irq_wanted;
    item_t                 in_item;

    task automatic report_mismatch(input string what);
        $display("%0t: mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic advance_irq_timer(input item_t it);
        logic [CountWidth-1:0] mask;
        if (it.func == FUNC_WRITE)
        begin
            case (it.reg_select)
                REG_NIB0, REG_NIB1, REG_NIB2, REG_NIB3:
                    reload_val[it.reg_select * NibbleWidth +: NibbleWidth] =
                        it.write_data[NibbleWidth-1:0];
                REG_CTRL:
                begin
                    ctrl_bits = it.write_data[CtrlWidth-1:0];
                    if (ctrl_bits[CTRL_ENABLE])
                    begin
                        count_val = reload_val;
                    end
                    irq_flag = 1'b0;
                end
                REG_ACK:
                begin
                    ctrl_bits[CTRL_ENABLE] = ctrl_bits[CTRL_ACK_ENABLE];
                    irq_flag = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
        else if (ctrl_bits[CTRL_ENABLE])
        begin
            mask = ctrl_bits[CTRL_MODE8] ? 16'h00FF : 16'hFFFF;
            if ((count_val & mask) == mask)
            begin
                count_val = reload_val;
                irq_flag  = 1'b1;
            end
            else
            begin
                count_val = count_val + 1'b1;
            end
        end
        irq_expect_q.push_back(irq_flag);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reload_val = '0;
            count_val  = '0;
            ctrl_bits  = '0;
            irq_flag   = 1'b0;
            irq_expect_q.delete();
            results_pending = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (irq_expect_q.size() == 0)
                begin
                    report_mismatch($sformatf("result %02h with nothing expected",
                                              m_axis_tdata));
                end
                else
                begin
                    irq_wanted = irq_expect_q.pop_front();
                    if (m_axis_tdata !== {7'b0, irq_wanted})
                    begin
                        report_mismatch($sformatf("irq_active: got %02h, expected %02h",
                                                  m_axis_tdata, {7'b0, irq_wanted}));
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                in_item.func       = s_axis_tuser[0];
                in_item.reg_select = s_axis_tdata[2:0];
                in_item.write_data = s_axis_tdata[10:3];
                advance_irq_timer(in_item);
            end
            results_pending = irq_expect_q.size();
        end
    end

endmodule

/* dv/reloading_irq_cycle_counter_tb.sv */
`timescale 1ns / 1ps
// Testbench top that feeds ticks and register writes to the IRQ counter and reports the verdict.
module reloading_irq_cycle_counter_tb;
    import rirq_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;  // [2:0] reg_select, [10:3] write_data, rest zero
    logic [0:0]  s_axis_tuser;  // [0] func
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;  // [0] irq_active, rest zero

    int mismatches;
    int results_pending;
    int items_sent;
    bit idle_on;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    reloading_irq_cycle_counter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    irq_counter_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .mismatches      (mismatches),
        .results_pending (results_pending)
    );

    function automatic item_t tick_item();
        item_t it;
        it.func       = FUNC_TICK;
        it.reg_select = SelWidth'($urandom_range(0, 7));
        it.write_data = DataWidth'($urandom_range(0, 255));
        return it;
    endfunction

    function automatic item_t write_item(input logic [SelWidth-1:0] sel,
                                         input logic [DataWidth-1:0] data);
        item_t it;
        it.func       = FUNC_WRITE;
        it.reg_select = sel;
        it.write_data = data;
        return it;
    endfunction

    task automatic send_item(input item_t it);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.func;
        s_axis_tdata  <= {5'b0, it.write_data, it.reg_select};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        if (it.func == FUNC_TICK || it.reg_select <= REG_ACK)
        begin
            items_sent++;
        end
    endtask

    task automatic send_random(input int count);
        logic [SelWidth-1:0]  nib_sel[4];
        logic [DataWidth-1:0] data;
        item_t                it;
        int                   start;
        nib_sel = '{REG_NIB0, REG_NIB1, REG_NIB2, REG_NIB3};
        start = items_sent;
        while (items_sent - start < count)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    // Mostly all-ones upper nibbles so the counter reaches its match quickly.
                    for (int i = 0; i < 4; i++)
                    begin
                        data = DataWidth'($urandom_range(0, 255));
                        if (i != 0 && $urandom_range(0, 3) != 0)
                        begin
                            data[3:0] = 4'hF;
                        end
                        send_item(write_item(nib_sel[i], data));
                    end
                end
                2, 3:
                begin
                    data = DataWidth'($urandom_range(0, 255));
                    data[CTRL_ENABLE] = ($urandom_range(0, 3) != 0);
                    send_item(write_item(REG_CTRL, data));
                end
                4:
                    send_item(write_item(REG_ACK, DataWidth'($urandom_range(0, 255))));
                5:
                begin
                    it.func       = 1'($urandom_range(0, 1));
                    it.reg_select = SelWidth'($urandom_range(0, 7));
                    it.write_data = DataWidth'($urandom_range(0, 255));
                    send_item(it);
                end
                default:
                    repeat ($urandom_range(1, 24)) send_item(tick_item());
            endcase
        end
    endtask

    initial
    begin
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (idle_on && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    initial
    begin
        #400000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        idle_on       = 1'b1;
        items_sent    = 0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(tick_item());
        send_item(write_item(REG_NIB0, 8'hFE));
        send_item(write_item(REG_NIB1, 8'hAF));
        send_item(write_item(REG_NIB2, 8'h5F));
        send_item(write_item(REG_NIB3, 8'h0F));
        send_item(tick_item());
        send_item(write_item(REG_CTRL, 8'hFA));
        send_item(tick_item());
        send_item(tick_item());
        send_item(tick_item());
        send_item(write_item(REG_ACK, 8'hFF));
        send_item(tick_item());
        send_item(write_item(REG_CTRL, 8'h07));
        send_item(tick_item());
        send_item(tick_item());
        send_item(write_item(3'd6, 8'hFF));
        send_item(write_item(3'd7, 8'h00));
        send_item(write_item(REG_ACK, 8'h00));
        send_item(write_item(REG_NIB0, 8'h00));
        send_item(tick_item());
        send_item(tick_item());
        send_item(tick_item());
        send_item(write_item(REG_CTRL, 8'h00));
        send_item(tick_item());

        send_random(1700);
        idle_on = 1'b0;
        send_random(300);
        s_axis_tvalid <= 1'b0;

        do @(negedge clk); while (results_pending != 0);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/rirq_pkg.sv
design/rirq_in_stage.sv
design/rirq_core.sv
design/reloading_irq_cycle_counter.sv
design/rirq_checker.sv
dv/irq_counter_checker.sv
dv/reloading_irq_cycle_counter_tb.sv
